// ----- rtl/bwfc_pkg.sv -----
// ----------------------------------------------------------------------------
// bwfc_pkg
// Shared types, constants and register codes for the battery window fault
// classifier.
// ----------------------------------------------------------------------------
package bwfc_pkg;

  // Sizing
  localparam int WINDOW_DEPTH = 5;
  localparam int MAX_CELLS    = 16;
  localparam int NCELL_CAT    = 8;
  localparam int NCAT         = 10;
  localparam int COUNT_W      = $clog2(MAX_CELLS + 1);
  localparam int TOTAL_W      = $clog2(WINDOW_DEPTH * MAX_CELLS + 1);
  localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int NFLAG        = 5;
  // Width of the total against threshold compare
  localparam int THR_CMP_W    = (TOTAL_W > 8) ? TOTAL_W : 8;

  // Stream widths
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Category indexes (cell categories first, then pack current)
  localparam int CAT_OV_FAULT = 0;
  localparam int CAT_UV_FAULT = 1;
  localparam int CAT_OV_WARN  = 2;
  localparam int CAT_UV_WARN  = 3;
  localparam int CAT_OT_FAULT = 4;
  localparam int CAT_UT_FAULT = 5;
  localparam int CAT_OT_WARN  = 6;
  localparam int CAT_UT_WARN  = 7;
  localparam int CAT_OC_FAULT = 8;
  localparam int CAT_OC_WARN  = 9;

  // Flag bit positions
  localparam int FLAG_OV = 0;
  localparam int FLAG_UV = 1;
  localparam int FLAG_OC = 2;
  localparam int FLAG_OT = 3;
  localparam int FLAG_UT = 4;

  // Register reset values
  localparam logic [31:0] RST_VOLT_FAULT = 32'd278530800;
  localparam logic [31:0] RST_VOLT_WARN  = 32'd271977400;
  localparam logic [31:0] RST_TEMP_FAULT = 32'd39386936;
  localparam logic [31:0] RST_TEMP_WARN  = 32'd32768000;
  localparam logic [30:0] RST_CUR_FAULT  = 31'd100000;
  localparam logic [30:0] RST_CUR_WARN   = 31'd80000;
  localparam logic [7:0]  RST_THRESHOLD  = 8'd3;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLT_FAULT = 3'd0,
    REG_VOLT_WARN  = 3'd1,
    REG_TEMP_FAULT = 3'd2,
    REG_TEMP_WARN  = 3'd3,
    REG_CUR_FAULT  = 3'd4,
    REG_CUR_WARN   = 3'd5,
    REG_THRESHOLD  = 3'd6
  } reg_index_t;

  // Decoded configuration
  typedef struct packed {
    logic        [15:0] vf_high;
    logic        [15:0] vf_low;
    logic        [15:0] vw_high;
    logic        [15:0] vw_low;
    logic signed [15:0] tf_max;
    logic signed [15:0] tf_min;
    logic signed [15:0] tw_max;
    logic signed [15:0] tw_min;
    logic        [30:0] cur_fault;
    logic        [30:0] cur_warn;
    logic        [7:0]  threshold;
  } cfg_t;

  // Classified item from the cell stage
  typedef struct packed {
    logic                 valid;
    logic [NCELL_CAT-1:0] hits;
    logic                 cur_fault;
    logic                 cur_warn;
    logic                 last;
    logic [31:0]          time_ms;
  } cell_item_t;

  // Per-sample counts held in one ring slot
  typedef struct packed {
    logic                               cur_warn;
    logic                               cur_fault;
    logic [NCELL_CAT-1:0][COUNT_W-1:0]  cells;
  } slot_t;

  // Closed sample with updated window totals
  typedef struct packed {
    logic                          valid;
    logic [31:0]                   time_ms;
    logic [NCAT-1:0][TOTAL_W-1:0]  totals;
  } window_t;

endpackage

// ----- rtl/bwfc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bwfc_cfg_regs
// Configuration register file: decodes writes and holds the limits.
// ----------------------------------------------------------------------------
module bwfc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bwfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bwfc_pkg::CFG_DATA_W-1:0] cfg_data,
  output bwfc_pkg::cfg_t                 cfg
);
  import bwfc_pkg::*;

  logic [31:0] volt_fault;
  logic [31:0] volt_warn;
  logic [31:0] temp_fault;
  logic [31:0] temp_warn;
  logic [30:0] cur_fault;
  logic [30:0] cur_warn;
  logic [7:0]  threshold;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      volt_fault <= RST_VOLT_FAULT;
      volt_warn  <= RST_VOLT_WARN;
      temp_fault <= RST_TEMP_FAULT;
      temp_warn  <= RST_TEMP_WARN;
      cur_fault  <= RST_CUR_FAULT;
      cur_warn   <= RST_CUR_WARN;
      threshold  <= RST_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_VOLT_FAULT: volt_fault <= cfg_data;
        REG_VOLT_WARN:  volt_warn  <= cfg_data;
        REG_TEMP_FAULT: temp_fault <= cfg_data;
        REG_TEMP_WARN:  temp_warn  <= cfg_data;
        REG_CUR_FAULT:  cur_fault  <= cfg_data[30:0];
        REG_CUR_WARN:   cur_warn   <= cfg_data[30:0];
        REG_THRESHOLD:  threshold  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Split packed windows into limits
  always_comb begin
    cfg.vf_high   = volt_fault[31:16];
    cfg.vf_low    = volt_fault[15:0];
    cfg.vw_high   = volt_warn[31:16];
    cfg.vw_low    = volt_warn[15:0];
    cfg.tf_max    = temp_fault[31:16];
    cfg.tf_min    = temp_fault[15:0];
    cfg.tw_max    = temp_warn[31:16];
    cfg.tw_min    = temp_warn[15:0];
    cfg.cur_fault = cur_fault;
    cfg.cur_warn  = cur_warn;
    cfg.threshold = threshold;
  end

endmodule

// ----- rtl/bwfc_cell_stage.sv -----
// ----------------------------------------------------------------------------
// bwfc_cell_stage
// Input register and per-cell classification of voltage, temperature and
// pack current.
// ----------------------------------------------------------------------------
module bwfc_cell_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata fields, low bit up: cell_mv[15:0], cell_temp_c10[31:16],
  // pack_cur_ma[63:32], sample_time_ms[95:64]
  input  logic [bwfc_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                           s_tlast,
  input  bwfc_pkg::cfg_t                 cfg,
  input  logic                           take,
  output bwfc_pkg::cell_item_t           item
);
  import bwfc_pkg::*;

  logic               valid;
  logic [15:0]        volt_mv;
  logic signed [15:0] temp_c10;
  logic [31:0]        current_ma;
  logic [31:0]        time_ms;
  logic               last;
  logic [31:0]        cur_mag;
  logic               cur_over_fault;

  assign s_tready = !valid || take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      volt_mv    <= s_tdata[15:0];
      temp_c10   <= s_tdata[31:16];
      current_ma <= s_tdata[63:32];
      time_ms    <= s_tdata[95:64];
      last       <= s_tlast;
    end
  end

  // Magnitude; the most negative value maps to 2^31
  assign cur_mag        = current_ma[31] ? (~current_ma + 32'd1) : current_ma;
  assign cur_over_fault = cur_mag > {1'b0, cfg.cur_fault};

  // Classification, first match wins in each group
  always_comb begin
    item.hits = '0;
    if (volt_mv > cfg.vf_high) begin
      item.hits[CAT_OV_FAULT] = 1'b1;
    end else if (volt_mv < cfg.vf_low) begin
      item.hits[CAT_UV_FAULT] = 1'b1;
    end else if (volt_mv > cfg.vw_high) begin
      item.hits[CAT_OV_WARN] = 1'b1;
    end else if (volt_mv < cfg.vw_low) begin
      item.hits[CAT_UV_WARN] = 1'b1;
    end

    if (temp_c10 > cfg.tf_max) begin
      item.hits[CAT_OT_FAULT] = 1'b1;
    end else if (temp_c10 < cfg.tf_min) begin
      item.hits[CAT_UT_FAULT] = 1'b1;
    end else if (temp_c10 > cfg.tw_max) begin
      item.hits[CAT_OT_WARN] = 1'b1;
    end else if (temp_c10 < cfg.tw_min) begin
      item.hits[CAT_UT_WARN] = 1'b1;
    end

    item.valid     = valid;
    item.cur_fault = cur_over_fault;
    item.cur_warn  = !cur_over_fault && (cur_mag > {1'b0, cfg.cur_warn});
    item.last      = last;
    item.time_ms   = time_ms;
  end

endmodule

// ----- rtl/bwfc_window.sv -----
// ----------------------------------------------------------------------------
// bwfc_window
// Open-sample counters, ring of per-sample counts and running window totals.
// ----------------------------------------------------------------------------
module bwfc_window (
  input  logic                 clk,
  input  logic                 rst,
  input  bwfc_pkg::cell_item_t item,
  output logic                 take,
  input  logic                 out_ready,
  output bwfc_pkg::window_t    win
);
  import bwfc_pkg::*;

  logic [NCELL_CAT-1:0][COUNT_W-1:0] open_counts;
  logic [NCELL_CAT-1:0][COUNT_W-1:0] open_next;
  slot_t                             ring [WINDOW_DEPTH];
  slot_t                             old_slot;
  slot_t                             new_slot;
  logic [NCAT-1:0][TOTAL_W-1:0]      totals;
  logic [NCAT-1:0][TOTAL_W-1:0]      totals_next;
  logic [NCAT-1:0][COUNT_W-1:0]      old_cnt;
  logic [NCAT-1:0][COUNT_W-1:0]      new_cnt;
  logic [SLOT_W-1:0]                 write_slot;
  logic [31:0]                       time_ms;
  logic                              valid;
  logic                              adv;
  logic                              close;

  // A closing item needs room in the totals stage
  assign take  = !item.last || !valid || out_ready;
  assign adv   = item.valid && take;
  assign close = adv && item.last;

  // Saturating open-sample counts including this cell
  always_comb begin
    for (int k = 0; k < NCELL_CAT; k++) begin
      if (item.hits[k] && (open_counts[k] < COUNT_W'(MAX_CELLS))) begin
        open_next[k] = open_counts[k] + COUNT_W'(1);
      end else begin
        open_next[k] = open_counts[k];
      end
    end
  end

  // Slot being replaced and its replacement
  always_comb begin
    old_slot           = ring[write_slot];
    new_slot.cells     = open_next;
    new_slot.cur_fault = item.cur_fault;
    new_slot.cur_warn  = item.cur_warn;
    for (int k = 0; k < NCELL_CAT; k++) begin
      old_cnt[k] = old_slot.cells[k];
      new_cnt[k] = new_slot.cells[k];
    end
    old_cnt[CAT_OC_FAULT] = COUNT_W'(old_slot.cur_fault);
    old_cnt[CAT_OC_WARN]  = COUNT_W'(old_slot.cur_warn);
    new_cnt[CAT_OC_FAULT] = COUNT_W'(new_slot.cur_fault);
    new_cnt[CAT_OC_WARN]  = COUNT_W'(new_slot.cur_warn);
  end

  // Incremental window sums
  always_comb begin
    for (int k = 0; k < NCAT; k++) begin
      totals_next[k] = totals[k] - TOTAL_W'(old_cnt[k]) + TOTAL_W'(new_cnt[k]);
    end
  end

  // Sample state
  always_ff @(posedge clk) begin
    if (rst) begin
      open_counts <= '0;
      totals      <= '0;
      write_slot  <= '0;
      valid       <= 1'b0;
      for (int s = 0; s < WINDOW_DEPTH; s++) begin
        ring[s] <= '0;
      end
    end else begin
      if (close) begin
        open_counts      <= '0;
        ring[write_slot] <= new_slot;
        totals           <= totals_next;
        write_slot       <= (write_slot == SLOT_W'(WINDOW_DEPTH - 1)) ?
                            '0 : write_slot + SLOT_W'(1);
        valid            <= 1'b1;
      end else begin
        if (adv) begin
          open_counts <= open_next;
        end
        if (valid && out_ready) begin
          valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (close) begin
      time_ms <= item.time_ms;
    end
  end

  assign win.valid   = valid;
  assign win.time_ms = time_ms;
  assign win.totals  = totals;

endmodule

// ----- rtl/bwfc_flag_out.sv -----
// ----------------------------------------------------------------------------
// bwfc_flag_out
// Threshold priority chains and the result output register.
// ----------------------------------------------------------------------------
module bwfc_flag_out (
  input  logic                            clk,
  input  logic                            rst,
  input  bwfc_pkg::window_t               win,
  input  logic [7:0]                      threshold,
  output logic                            out_ready,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata fields, low bit up: result_time_ms[31:0], fault_bits[36:32],
  // warn_bits[41:37], zero fill[47:42]
  output logic [bwfc_pkg::OUT_DATA_W-1:0] m_tdata
);
  import bwfc_pkg::*;

  logic [NCAT-1:0]  met;
  logic [NFLAG-1:0] ff;
  logic [NFLAG-1:0] wf;
  logic [31:0]      time_ms;
  logic [NFLAG-1:0] fault_bits;
  logic [NFLAG-1:0] warn_bits;

  assign out_ready = !m_tvalid || m_tready;

  // Totals against threshold
  always_comb begin
    for (int k = 0; k < NCAT; k++) begin
      met[k] = THR_CMP_W'(win.totals[k]) >= THR_CMP_W'(threshold);
    end
  end

  // Priority chains, only the first met link sets its flag
  always_comb begin
    ff = '0;
    wf = '0;
    if (met[CAT_OV_FAULT]) begin
      ff[FLAG_OV] = 1'b1;
    end else if (met[CAT_OV_WARN]) begin
      wf[FLAG_OV] = 1'b1;
    end else if (met[CAT_UV_FAULT]) begin
      ff[FLAG_UV] = 1'b1;
    end else if (met[CAT_UV_WARN]) begin
      wf[FLAG_UV] = 1'b1;
    end

    if (met[CAT_OC_FAULT]) begin
      ff[FLAG_OC] = 1'b1;
    end else if (met[CAT_OC_WARN]) begin
      wf[FLAG_OC] = 1'b1;
    end

    if (met[CAT_OT_FAULT]) begin
      ff[FLAG_OT] = 1'b1;
    end else if (met[CAT_OT_WARN]) begin
      wf[FLAG_OT] = 1'b1;
    end else if (met[CAT_UT_FAULT]) begin
      ff[FLAG_UT] = 1'b1;
    end else if (met[CAT_UT_WARN]) begin
      wf[FLAG_UT] = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= win.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (win.valid && out_ready) begin
      time_ms    <= win.time_ms;
      fault_bits <= ff;
      warn_bits  <= wf;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - 32 - 2 * NFLAG){1'b0}}, warn_bits, fault_bits, time_ms};

endmodule

// ----- rtl/battery_window_fault_classifier.sv -----
// ----------------------------------------------------------------------------
// battery_window_fault_classifier
// Classifies cell readings and raises fault and warning flags from counts
// over a sliding window of recent samples.
// ----------------------------------------------------------------------------
// Takes one cell reading per clock unless a closing item waits for room in
// the output path; the item with s_tlast set closes the sample and supplies
// pack current and timestamp. Each closed sample yields one result on the
// master side: m_tvalid rises once the closing item has passed the input
// register, the window totals register and the output register; other items
// yield nothing. That rate is held by the open-sample counters and the
// running window totals, which replace the oldest ring slot on each closed
// sample. The user must write limits through the cfg port only while the
// block is idle; the block itself does not enforce it.
module battery_window_fault_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata fields, low bit up: cell_mv[15:0], cell_temp_c10[31:16],
  // pack_cur_ma[63:32], sample_time_ms[95:64]
  input  logic [bwfc_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata fields, low bit up: result_time_ms[31:0], fault_bits[36:32],
  // warn_bits[41:37], zero fill[47:42]
  output logic [bwfc_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bwfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bwfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bwfc_pkg::*;

  cfg_t       cfg;
  cell_item_t item;
  window_t    win;
  logic       take;
  logic       out_ready;

  bwfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bwfc_cell_stage u_cell (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .cfg      (cfg),
    .take     (take),
    .item     (item)
  );

  bwfc_window u_window (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .take      (take),
    .out_ready (out_ready),
    .win       (win)
  );

  bwfc_flag_out u_flags (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .threshold (cfg.threshold),
    .out_ready (out_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
